[rtl/zzdr_pkg.sv]
// zzdr_pkg: shared constants and types for the zigzag diagonal reorder block
// no dependencies; used by zzdr_ctrl, zzdr_datapath and zigzag_diagonal_reorder
`timescale 1ns / 1ps

package zzdr_pkg;

  localparam int MAX_ROWS   = 8;
  localparam int MAX_COLS   = 8;
  localparam int DATA_WIDTH = 32;

  localparam int DEPTH  = MAX_ROWS * MAX_COLS;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int ROW_W  = 3;
  localparam int COL_W  = 3;
  localparam int CFG_W  = 4;
  localparam int IDX_W  = 2;

  localparam logic [CFG_W-1:0] ROWS_MAX  = CFG_W'(MAX_ROWS);
  localparam logic [CFG_W-1:0] COLS_MAX  = CFG_W'(MAX_COLS);
  localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(8);

  // configuration register indexes
  localparam logic [IDX_W-1:0] REG_ROW_COUNT = IDX_W'(0);
  localparam logic [IDX_W-1:0] REG_COL_COUNT = IDX_W'(1);

  typedef enum logic [1:0] {
    ST_LOAD = 2'b01,
    ST_EMIT = 2'b10
  } state_e;

  typedef struct packed {
    logic load;   // element word accepted
    logic issue;  // read next element of the walk into the output register
  } cmd_t;

  typedef struct packed {
    logic load_done;  // this load completes the matrix
    logic at_last;    // walker sits on the final element
  } status_t;

endpackage

[rtl/zzdr_ctrl.sv]
// zzdr_ctrl: load / emit state machine and output valid flag
// depends on zzdr_pkg
`timescale 1ns / 1ps

module zzdr_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  zzdr_pkg::status_t sts_i,
  output zzdr_pkg::cmd_t    cmd_o
);

  zzdr_pkg::state_e state_q, state_d;
  logic             out_valid_q, out_valid_d;
  logic             issue;

  assign in_ready_o  = (state_q == zzdr_pkg::ST_LOAD);
  assign out_valid_o = out_valid_q;

  // output register is free when empty or being taken this cycle
  assign issue = (state_q == zzdr_pkg::ST_EMIT) && (!out_valid_q || out_ready_i);

  assign cmd_o.load  = in_valid_i && in_ready_o;
  assign cmd_o.issue = issue;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      zzdr_pkg::ST_LOAD: begin
        if (cmd_o.load && sts_i.load_done) state_d = zzdr_pkg::ST_EMIT;
      end
      zzdr_pkg::ST_EMIT: begin
        if (issue && sts_i.at_last) state_d = zzdr_pkg::ST_LOAD;
      end
      default: state_d = zzdr_pkg::ST_LOAD;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (issue) out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= zzdr_pkg::ST_LOAD;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

[rtl/zzdr_datapath.sv]
// zzdr_datapath: element store, load counter, diagonal walker and output registers
// depends on zzdr_pkg
`timescale 1ns / 1ps

module zzdr_datapath (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [zzdr_pkg::IDX_W-1:0]            cfg_index_i,
  input  logic [zzdr_pkg::CFG_W-1:0]            cfg_data_i,
  input  logic signed [zzdr_pkg::DATA_WIDTH-1:0] element_value_i,
  input  zzdr_pkg::cmd_t                        cmd_i,
  output zzdr_pkg::status_t                     sts_o,
  output logic signed [zzdr_pkg::DATA_WIDTH-1:0] out_value_o,
  output logic [zzdr_pkg::ROW_W-1:0]            row_index_o,
  output logic [zzdr_pkg::COL_W-1:0]            col_index_o,
  output logic                                  last_of_run_o
);

  logic [zzdr_pkg::DATA_WIDTH-1:0] mem [zzdr_pkg::DEPTH];

  logic [zzdr_pkg::CFG_W-1:0]  row_cfg_q, col_cfg_q;
  logic [zzdr_pkg::CFG_W-1:0]  rows_eff, cols_eff;
  logic [zzdr_pkg::CNT_W-1:0]  total, loaded_q, loaded_d, loaded_inc;
  logic [zzdr_pkg::CNT_W-1:0]  k_q, k_d;
  logic [zzdr_pkg::ROW_W-1:0]  r_q, r_d;
  logic [zzdr_pkg::COL_W-1:0]  c_q, c_d;
  logic                        up_q, up_d;
  logic [zzdr_pkg::ADDR_W-1:0] rd_addr;
  logic [zzdr_pkg::CFG_W-1:0]  r_next, c_next;
  logic                        write_en;

  // zero size counts as one, oversize clamps to the store dimensions
  always_comb begin
    rows_eff = row_cfg_q;
    if (row_cfg_q == '0) rows_eff = zzdr_pkg::CFG_W'(1);
    else if (row_cfg_q > zzdr_pkg::ROWS_MAX) rows_eff = zzdr_pkg::ROWS_MAX;
    cols_eff = col_cfg_q;
    if (col_cfg_q == '0) cols_eff = zzdr_pkg::CFG_W'(1);
    else if (col_cfg_q > zzdr_pkg::COLS_MAX) cols_eff = zzdr_pkg::COLS_MAX;
  end

  assign total = zzdr_pkg::CNT_W'(rows_eff) * zzdr_pkg::CNT_W'(cols_eff);
  assign loaded_inc = loaded_q + zzdr_pkg::CNT_W'(1);

  // after a shrink the count may already cover the matrix: word is dropped
  assign write_en = cmd_i.load && (loaded_q < total);

  assign sts_o.load_done = (loaded_inc >= total);
  assign sts_o.at_last   = (k_q == total - zzdr_pkg::CNT_W'(1));

  assign rd_addr = zzdr_pkg::ADDR_W'(r_q) * zzdr_pkg::ADDR_W'(cols_eff)
                 + zzdr_pkg::ADDR_W'(c_q);

  assign r_next = zzdr_pkg::CFG_W'(r_q) + zzdr_pkg::CFG_W'(1);
  assign c_next = zzdr_pkg::CFG_W'(c_q) + zzdr_pkg::CFG_W'(1);

  always_comb begin
    loaded_d = loaded_q;
    k_d      = k_q;
    r_d      = r_q;
    c_d      = c_q;
    up_d     = up_q;
    if (cmd_i.load) begin
      if (sts_o.load_done) begin
        loaded_d = '0;
        k_d      = '0;
        r_d      = '0;
        c_d      = '0;
        up_d     = 1'b1;
      end else begin
        loaded_d = loaded_inc;
      end
    end else if (cmd_i.issue) begin
      k_d = k_q + zzdr_pkg::CNT_W'(1);
      if (up_q) begin
        // right edge checked before top edge
        if (c_next >= cols_eff) begin
          r_d  = r_q + zzdr_pkg::ROW_W'(1);
          up_d = 1'b0;
        end else if (r_q == '0) begin
          c_d  = c_q + zzdr_pkg::COL_W'(1);
          up_d = 1'b0;
        end else begin
          r_d = r_q - zzdr_pkg::ROW_W'(1);
          c_d = c_q + zzdr_pkg::COL_W'(1);
        end
      end else begin
        // bottom edge checked before left edge
        if (r_next >= rows_eff) begin
          c_d  = c_q + zzdr_pkg::COL_W'(1);
          up_d = 1'b1;
        end else if (c_q == '0) begin
          r_d  = r_q + zzdr_pkg::ROW_W'(1);
          up_d = 1'b1;
        end else begin
          r_d = r_q + zzdr_pkg::ROW_W'(1);
          c_d = c_q - zzdr_pkg::COL_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_cfg_q <= zzdr_pkg::CFG_RESET;
      col_cfg_q <= zzdr_pkg::CFG_RESET;
      loaded_q  <= '0;
      k_q       <= '0;
      r_q       <= '0;
      c_q       <= '0;
      up_q      <= 1'b1;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          zzdr_pkg::REG_ROW_COUNT: row_cfg_q <= cfg_data_i;
          zzdr_pkg::REG_COL_COUNT: col_cfg_q <= cfg_data_i;
          default: ;
        endcase
      end
      loaded_q <= loaded_d;
      k_q      <= k_d;
      r_q      <= r_d;
      c_q      <= c_d;
      up_q     <= up_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (write_en) mem[loaded_q[zzdr_pkg::ADDR_W-1:0]] <= element_value_i;
  end

  // registered read port doubles as the output payload register
  always_ff @(posedge clk_i) begin
    if (cmd_i.issue) begin
      out_value_o   <= mem[rd_addr];
      row_index_o   <= r_q;
      col_index_o   <= c_q;
      last_of_run_o <= sts_o.at_last;
    end
  end

endmodule

[rtl/zigzag_diagonal_reorder.sv]
// zigzag_diagonal_reorder: loads one word per cycle in row-major order, then
// emits the matrix in zigzag diagonal order from the store's registered read
// port, one word per cycle while the output is not held. Once the last word is
// accepted, the state moves to emit, then the first result is registered and
// flagged valid. Reset clears control state, load count and sizes (8 x 8); the
// store is not cleared and holds garbage until written.
`timescale 1ns / 1ps

module zigzag_diagonal_reorder (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [zzdr_pkg::IDX_W-1:0]            cfg_index_i,
  input  logic [zzdr_pkg::CFG_W-1:0]            cfg_data_i,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic signed [zzdr_pkg::DATA_WIDTH-1:0] element_value_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic signed [zzdr_pkg::DATA_WIDTH-1:0] out_value_o,
  output logic [zzdr_pkg::ROW_W-1:0]            row_index_o,
  output logic [zzdr_pkg::COL_W-1:0]            col_index_o,
  output logic                                  last_of_run_o
);

  zzdr_pkg::cmd_t    cmd;
  zzdr_pkg::status_t sts;

  assign cfg_ready_o = 1'b1;

  zzdr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  zzdr_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_valid_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .element_value_i (element_value_i),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .out_value_o     (out_value_o),
    .row_index_o     (row_index_o),
    .col_index_o     (col_index_o),
    .last_of_run_o   (last_of_run_o)
  );

endmodule
